// ===== rtl/core/bepp_pkg.sv =====
package bepp_pkg;

    // sizing of the block store and the processor range
    localparam int MAX_BLOCKS = 16;
    localparam int MAX_PROCS  = 32;
    localparam int DIMS       = 3;
    localparam int MAX_LEVEL  = 10;

    localparam int LEVEL_W    = 4;
    localparam int EXP_W      = 5;
    localparam int BLK_IDX_W  = $clog2(MAX_BLOCKS);
    localparam int BLK_CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int PROC_W     = 6;
    localparam int REM_W      = $clog2(MAX_PROCS);
    localparam int TOTAL_W    = 35;
    localparam int LIB_W      = 31;
    localparam int MASK_W     = 32;
    localparam int OUT_BLK_W  = 4;

    // register indexes on the config port
    localparam logic REG_NUM_PROCS   = 1'b0;
    localparam logic REG_IGNORE_MASK = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_PROC,
        ST_RUN
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic start_div;
        logic walk_init;
        logic proc_skip;
        logic proc_load;
        logic proc_next;
        logic emit;
        logic clear;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic procs_done;
        logic ignored;
        logic run_ok;
        logic out_free;
    } status_t;

endpackage

// ===== rtl/core/bepp_div.sv =====
module bepp_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [bepp_pkg::TOTAL_W-1:0]      dividend,
    input  logic [bepp_pkg::PROC_W-1:0]       divisor,
    output logic [bepp_pkg::TOTAL_W-1:0]      quotient,
    output logic [bepp_pkg::REM_W-1:0]        remainder,
    output logic                              done
);

    localparam int CNT_W = $clog2(bepp_pkg::TOTAL_W);

    logic [bepp_pkg::TOTAL_W-1:0] quo_reg, quo_next;
    logic [bepp_pkg::REM_W-1:0]   rem_reg, rem_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic                         busy_reg, busy_next;
    logic [bepp_pkg::REM_W:0]     trial;
    logic                         fits;

    // one restoring step per cycle, quotient bits shift in from the bottom
    always_comb
    begin
        trial     = {rem_reg, quo_reg[bepp_pkg::TOTAL_W-1]};
        fits      = trial >= divisor;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done      = busy_reg && (cnt_reg == CNT_W'(bepp_pkg::TOTAL_W - 1));
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[bepp_pkg::TOTAL_W-2:0], fits};
            rem_next = fits ? bepp_pkg::REM_W'(trial - divisor)
                            : trial[bepp_pkg::REM_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (done)
            begin
                busy_next = 1'b0;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/core/bepp_dpath.sv =====
module bepp_dpath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  bepp_pkg::cmd_t                     cmd,
    output bepp_pkg::status_t                  status,
    input  logic [bepp_pkg::PROC_W-1:0]        nprocs,
    input  logic [bepp_pkg::MASK_W-1:0]        mask,
    input  logic [bepp_pkg::LEVEL_W-1:0]       ref_x,
    input  logic [bepp_pkg::LEVEL_W-1:0]       ref_y,
    input  logic [bepp_pkg::LEVEL_W-1:0]       ref_z,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [bepp_pkg::OUT_BLK_W-1:0]     block_index,
    output logic [bepp_pkg::PROC_W-1:0]        proc_number,
    output logic [bepp_pkg::TOTAL_W-1:0]       element_count,
    output logic                               last_run
);

    localparam int TW = bepp_pkg::TOTAL_W;
    localparam int LW = bepp_pkg::LIB_W;
    localparam int CW = bepp_pkg::BLK_CNT_W;
    localparam int PW = bepp_pkg::PROC_W;

    // exponent store, undefined until written
    logic [bepp_pkg::EXP_W-1:0] exp_mem [bepp_pkg::MAX_BLOCKS];

    logic [CW-1:0] block_count_reg, block_count_next;
    logic [TW-1:0] total_reg, total_next;
    logic [CW-1:0] cur_reg, cur_next;
    logic [LW-1:0] lib_reg, lib_next;
    logic [TW-1:0] lop_reg, lop_next;
    logic [PW-1:0] p_reg, p_next;
    logic [PW-1:0] skipped_reg, skipped_next;
    logic          out_valid_reg, out_valid_next;
    logic [bepp_pkg::OUT_BLK_W-1:0] block_index_reg;
    logic [PW-1:0] proc_number_reg;
    logic [TW-1:0] element_count_reg;
    logic          last_run_reg;

    logic [bepp_pkg::LEVEL_W-1:0] lvl_x, lvl_y, lvl_z;
    logic [bepp_pkg::EXP_W-1:0]   exp_sum;
    logic                         room;
    logic [CW-1:0]                cur_inc;
    logic [bepp_pkg::BLK_IDX_W-1:0] rd_addr;
    logic [bepp_pkg::EXP_W-1:0]   exp_rd;
    logic [LW-1:0]                rd_size;
    logic [TW-1:0]                lib_ext;
    logic                         adv;
    logic [TW-1:0]                run_len;
    logic [PW-1:0]                global_proc;
    logic [TW-1:0]                quotient;
    logic [bepp_pkg::REM_W-1:0]   remainder;
    logic                         div_done;
    logic                         out_free;

    // level clamp and exponent of the incoming block
    always_comb
    begin
        lvl_x = (ref_x > bepp_pkg::LEVEL_W'(bepp_pkg::MAX_LEVEL))
                ? bepp_pkg::LEVEL_W'(bepp_pkg::MAX_LEVEL) : ref_x;
        lvl_y = (ref_y > bepp_pkg::LEVEL_W'(bepp_pkg::MAX_LEVEL))
                ? bepp_pkg::LEVEL_W'(bepp_pkg::MAX_LEVEL) : ref_y;
        lvl_z = (ref_z > bepp_pkg::LEVEL_W'(bepp_pkg::MAX_LEVEL))
                ? bepp_pkg::LEVEL_W'(bepp_pkg::MAX_LEVEL) : ref_z;
        exp_sum = bepp_pkg::EXP_W'(lvl_x)
                + ((bepp_pkg::DIMS >= 2) ? bepp_pkg::EXP_W'(lvl_y) : '0)
                + ((bepp_pkg::DIMS >= 3) ? bepp_pkg::EXP_W'(lvl_z) : '0);
        room = block_count_reg < CW'(bepp_pkg::MAX_BLOCKS);
    end

    // shared divider for quotient and remainder of the total
    bepp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.start_div),
        .dividend  (total_next),
        .divisor   (nprocs),
        .quotient  (quotient),
        .remainder (remainder),
        .done      (div_done)
    );

    // single read port of the exponent store
    always_comb
    begin
        cur_inc = cur_reg + 1'b1;
        rd_addr = cmd.walk_init ? '0 : cur_inc[bepp_pkg::BLK_IDX_W-1:0];
        exp_rd  = exp_mem[rd_addr];
        rd_size = LW'(1) << exp_rd;
    end

    // run length and processor lookup
    always_comb
    begin
        lib_ext     = TW'(lib_reg);
        adv         = lib_ext <= lop_reg;
        run_len     = adv ? lib_ext : lop_reg;
        global_proc = p_reg + skipped_reg;
        out_free    = !out_valid_reg || out_ready;
    end

    // next state of the walk
    always_comb
    begin
        block_count_next = block_count_reg;
        total_next       = total_reg;
        cur_next         = cur_reg;
        lib_next         = lib_reg;
        lop_next         = lop_reg;
        p_next           = p_reg;
        skipped_next     = skipped_reg;
        out_valid_next   = out_valid_reg && !out_ready;

        if (cmd.load && room)
        begin
            block_count_next = block_count_reg + 1'b1;
            total_next       = total_reg + (TW'(1) << exp_sum);
        end
        if (cmd.walk_init)
        begin
            cur_next     = '0;
            lib_next     = (block_count_reg != '0) ? rd_size : '0;
            p_next       = '0;
            skipped_next = '0;
        end
        if (cmd.proc_skip)
        begin
            skipped_next = skipped_reg + 1'b1;
        end
        if (cmd.proc_load)
        begin
            lop_next = quotient + TW'(p_reg < PW'(remainder));
        end
        if (cmd.proc_next)
        begin
            p_next = p_reg + 1'b1;
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            if (adv)
            begin
                lop_next = lop_reg - lib_ext;
                cur_next = cur_inc;
                lib_next = (cur_inc < block_count_reg) ? rd_size : '0;
            end
            else
            begin
                lib_next = lib_reg - LW'(lop_reg);
                lop_next = '0;
            end
        end
        if (cmd.clear)
        begin
            block_count_next = '0;
            total_next       = '0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg <= '0;
            total_reg       <= '0;
            cur_reg         <= '0;
            lib_reg         <= '0;
            lop_reg         <= '0;
            p_reg           <= '0;
            skipped_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            block_count_reg <= block_count_next;
            total_reg       <= total_next;
            cur_reg         <= cur_next;
            lib_reg         <= lib_next;
            lop_reg         <= lop_next;
            p_reg           <= p_next;
            skipped_reg     <= skipped_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // exponent store write and result register
    always_ff @(posedge clk)
    begin
        if (cmd.load && room)
        begin
            exp_mem[block_count_reg[bepp_pkg::BLK_IDX_W-1:0]] <= exp_sum;
        end
        if (cmd.emit)
        begin
            block_index_reg   <= bepp_pkg::OUT_BLK_W'(cur_reg);
            proc_number_reg   <= global_proc;
            element_count_reg <= run_len;
            last_run_reg      <= adv && (cur_inc == block_count_reg);
        end
    end

    // status back to the controller
    always_comb
    begin
        status.div_done   = div_done;
        status.procs_done = p_reg == nprocs;
        status.ignored    = (global_proc < PW'(bepp_pkg::MASK_W))
                            && mask[global_proc[bepp_pkg::REM_W-1:0]];
        status.run_ok     = (lop_reg != '0) && (cur_reg < block_count_reg);
        status.out_free   = out_free;
    end

    assign out_valid     = out_valid_reg;
    assign block_index   = block_index_reg;
    assign proc_number   = proc_number_reg;
    assign element_count = element_count_reg;
    assign last_run      = last_run_reg;

endmodule

// ===== rtl/core/bepp_ctrl.sv =====
module bepp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               last_block,
    input  bepp_pkg::status_t  status,
    output bepp_pkg::cmd_t     cmd
);

    bepp_pkg::state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bepp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            bepp_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (last_block)
                    begin
                        cmd.start_div = 1'b1;
                        state_next    = bepp_pkg::ST_DIVIDE;
                    end
                end
            end
            bepp_pkg::ST_DIVIDE:
            begin
                if (status.div_done)
                begin
                    cmd.walk_init = 1'b1;
                    state_next    = bepp_pkg::ST_PROC;
                end
            end
            bepp_pkg::ST_PROC:
            begin
                if (status.procs_done)
                begin
                    cmd.clear  = 1'b1;
                    state_next = bepp_pkg::ST_IDLE;
                end
                else if (status.ignored)
                begin
                    cmd.proc_skip = 1'b1;
                end
                else
                begin
                    cmd.proc_load = 1'b1;
                    state_next    = bepp_pkg::ST_RUN;
                end
            end
            bepp_pkg::ST_RUN:
            begin
                if (!status.run_ok)
                begin
                    cmd.proc_next = 1'b1;
                    state_next    = bepp_pkg::ST_PROC;
                end
                else if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                end
            end
            default:
            begin
                state_next = bepp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/block_element_proc_partition_top.sv =====
// Splits the elements of a mesh over processors in contiguous, balanced runs.
// Each block request carries per-dimension refinement levels; the block
// holds 2^(sum of levels) elements and up to 16 blocks are kept. A request
// marked last_block closes the mesh: a restoring divider computes
// total/num_procs, then the walk visits each processor in turn, skips the
// ignored processors, emits the runs of each processor and moves on to the
// next, and finally clears the mesh. Runs leave through a one-entry output
// register and stall only when it is full and not taken. New block requests
// are taken once the walk is done and the stored mesh has been cleared.
module block_element_proc_partition_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [bepp_pkg::LEVEL_W-1:0]       ref_x,
    input  logic [bepp_pkg::LEVEL_W-1:0]       ref_y,
    input  logic [bepp_pkg::LEVEL_W-1:0]       ref_z,
    input  logic                               last_block,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [bepp_pkg::OUT_BLK_W-1:0]     block_index,
    output logic [bepp_pkg::PROC_W-1:0]        proc_number,
    output logic [bepp_pkg::TOTAL_W-1:0]       element_count,
    output logic                               last_run
);

    logic [bepp_pkg::PROC_W-1:0] num_procs_reg;
    logic [bepp_pkg::MASK_W-1:0] ignore_mask_reg;
    logic [bepp_pkg::PROC_W-1:0] nprocs;
    logic                        cfg_write;
    bepp_pkg::cmd_t              cmd;
    bepp_pkg::status_t           status;

    // register write decode
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_procs_reg   <= bepp_pkg::PROC_W'(1);
            ignore_mask_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                bepp_pkg::REG_NUM_PROCS:
                begin
                    num_procs_reg <= pwdata[bepp_pkg::PROC_W-1:0];
                end
                bepp_pkg::REG_IGNORE_MASK:
                begin
                    ignore_mask_reg <= pwdata;
                end
                default:
                begin
                    num_procs_reg <= num_procs_reg;
                end
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (paddr[2])
            bepp_pkg::REG_NUM_PROCS:   prdata = 32'(num_procs_reg);
            bepp_pkg::REG_IGNORE_MASK: prdata = ignore_mask_reg;
            default:                   prdata = '0;
        endcase
    end

    // processor count limited to one through the maximum
    always_comb
    begin
        if (num_procs_reg == '0)
        begin
            nprocs = bepp_pkg::PROC_W'(1);
        end
        else if (num_procs_reg > bepp_pkg::PROC_W'(bepp_pkg::MAX_PROCS))
        begin
            nprocs = bepp_pkg::PROC_W'(bepp_pkg::MAX_PROCS);
        end
        else
        begin
            nprocs = num_procs_reg;
        end
    end

    bepp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .last_block (last_block),
        .status     (status),
        .cmd        (cmd)
    );

    bepp_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .nprocs        (nprocs),
        .mask          (ignore_mask_reg),
        .ref_x         (ref_x),
        .ref_y         (ref_y),
        .ref_z         (ref_z),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .block_index   (block_index),
        .proc_number   (proc_number),
        .element_count (element_count),
        .last_run      (last_run)
    );

    // a run is only issued into a free output slot with work left
    a_emit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (status.out_free && status.run_ok))
        else $error("run issued without room or work");

    // walk commands never overlap
    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.walk_init, cmd.proc_skip, cmd.proc_load,
                  cmd.proc_next, cmd.emit, cmd.clear}))
        else $error("overlapping walk commands");

    // the divider never finishes while block requests are taken
    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> !in_ready)
        else $error("divider finished while idle");

    // clearing the mesh returns to accepting blocks
    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> in_ready)
        else $error("not idle after clear");

endmodule

// ===== sim/tb_block_element_proc_partition_top.sv =====
module tb_block_element_proc_partition_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          HALF_PERIOD   = 10;
    localparam int          RANDOM_ITEMS  = 330;
    // divide, processor walk with skips and runs, with margin
    localparam int          SETTLE_CYCLES = 250;
    localparam int          HOLD_CYCLES   = 400;
    localparam int unsigned CYCLE_LIMIT   = 2000000;
    localparam longint unsigned TOTAL_MASK = (64'd1 << bepp_pkg::TOTAL_W) - 1;

    // one run of elements as it leaves the block
    typedef struct {
        logic [bepp_pkg::OUT_BLK_W-1:0] blk;
        logic [bepp_pkg::PROC_W-1:0]    proc;
        logic [bepp_pkg::TOTAL_W-1:0]   count;
        logic                           last;
    } elem_run_t;

    logic                            clk           = 1'b0;
    logic                            rst_n         = 1'b0;
    logic                            psel          = 1'b0;
    logic                            penable       = 1'b0;
    logic                            pwrite        = 1'b0;
    logic [2:0]                      paddr         = '0;
    logic [31:0]                     pwdata        = '0;
    logic [31:0]                     prdata;
    logic                            pready;
    logic                            in_valid      = 1'b0;
    logic                            in_ready;
    logic [bepp_pkg::LEVEL_W-1:0]    ref_x         = '0;
    logic [bepp_pkg::LEVEL_W-1:0]    ref_y         = '0;
    logic [bepp_pkg::LEVEL_W-1:0]    ref_z         = '0;
    logic                            last_block    = 1'b0;
    logic                            out_valid;
    logic                            out_ready     = 1'b0;
    logic [bepp_pkg::OUT_BLK_W-1:0]  block_index;
    logic [bepp_pkg::PROC_W-1:0]     proc_number;
    logic [bepp_pkg::TOTAL_W-1:0]    element_count;
    logic                            last_run;

    // shadow of the registers and of the stored mesh
    logic [5:0]                      cfg_procs     = 6'd1;
    logic [bepp_pkg::MASK_W-1:0]     cfg_mask      = '0;
    int                              mesh_exp [bepp_pkg::MAX_BLOCKS];
    int                              mesh_blocks   = 0;
    longint unsigned                 mesh_total    = 0;

    elem_run_t             runs_due [$];
    int                    fail_count    = 0;
    bit                    quiet         = 1'b0;
    bit                    hold_request  = 1'b0;
    int                    hold_left     = 0;
    int                    stall_left    = 0;
    int unsigned           cycle_count   = 0;

    block_element_proc_partition_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .ref_x         (ref_x),
        .ref_y         (ref_y),
        .ref_z         (ref_z),
        .last_block    (last_block),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .block_index   (block_index),
        .proc_number   (proc_number),
        .element_count (element_count),
        .last_run      (last_run)
    );

    // clock
    always #HALF_PERIOD clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // loads one block, and on the last block splits the mesh into expected runs
    task automatic predict_partition(input logic [bepp_pkg::LEVEL_W-1:0] lx,
                                     input logic [bepp_pkg::LEVEL_W-1:0] ly,
                                     input logic [bepp_pkg::LEVEL_W-1:0] lz,
                                     input logic is_last);
        logic [bepp_pkg::LEVEL_W-1:0] lv [3];
        int                 exp_sum;
        int                 nprocs;
        int                 blk;
        int                 gp;
        int                 skipped;
        int                 produced;
        int                 d;
        int                 p;
        longint unsigned    quot;
        longint unsigned    rem;
        longint unsigned    in_blk;
        longint unsigned    on_proc;
        longint unsigned    run_len;
        elem_run_t          pending;
        bit                 have_pending;

        lv[0] = lx;
        lv[1] = ly;
        lv[2] = lz;
        exp_sum = 0;
        // unused dimensions do not count, levels saturate
        for (d = 0; d < bepp_pkg::DIMS && d < 3; d++)
            exp_sum += (lv[d] > bepp_pkg::MAX_LEVEL) ? bepp_pkg::MAX_LEVEL : int'(lv[d]);

        // a full store drops the block
        if (mesh_blocks < bepp_pkg::MAX_BLOCKS)
        begin
            mesh_exp[mesh_blocks] = exp_sum;
            mesh_blocks++;
            mesh_total = (mesh_total + (64'd1 << exp_sum)) & TOTAL_MASK;
        end
        if (!is_last)
            return;

        nprocs = (cfg_procs == 0) ? 1
               : (cfg_procs > bepp_pkg::MAX_PROCS) ? bepp_pkg::MAX_PROCS : int'(cfg_procs);
        quot = mesh_total / nprocs;
        rem  = mesh_total % nprocs;
        blk = 0;
        in_blk = (mesh_blocks > 0) ? (64'd1 << mesh_exp[0]) : 0;
        skipped = 0;
        produced = 0;
        have_pending = 1'b0;

        // walk processors and blocks together, one run per overlap
        for (p = 0; p < nprocs; p++)
        begin
            gp = p + skipped;
            while (gp < bepp_pkg::MASK_W && cfg_mask[gp])
            begin
                skipped++;
                gp++;
            end
            on_proc = quot + ((p < rem) ? 1 : 0);
            while (on_proc > 0 && blk < mesh_blocks)
            begin
                run_len = (in_blk < on_proc) ? in_blk : on_proc;
                if (produced < bepp_pkg::MAX_BLOCKS + bepp_pkg::MAX_PROCS - 1)
                begin
                    if (have_pending)
                        runs_due.push_back(pending);
                    pending.blk   = blk[bepp_pkg::OUT_BLK_W-1:0];
                    pending.proc  = gp[bepp_pkg::PROC_W-1:0];
                    pending.count = run_len[bepp_pkg::TOTAL_W-1:0];
                    pending.last  = 1'b0;
                    have_pending  = 1'b1;
                    produced++;
                end
                if (in_blk <= on_proc)
                begin
                    on_proc -= in_blk;
                    blk++;
                    in_blk = (blk < mesh_blocks) ? (64'd1 << mesh_exp[blk]) : 0;
                end
                else
                begin
                    in_blk -= on_proc;
                    on_proc = 0;
                end
            end
        end

        // final run of the distribution is flagged
        if (have_pending)
        begin
            pending.last = 1'b1;
            runs_due.push_back(pending);
        end
        mesh_blocks = 0;
        mesh_total  = 0;
    endtask

    // result checker and receiver readiness
    always @(posedge clk)
    begin : sink_proc
        elem_run_t want;

        if (rst_n && out_valid && out_ready)
        begin
            if (runs_due.size() == 0)
            begin
                $error("run with no prediction: block_index %0d proc_number %0d count %0d",
                       block_index, proc_number, element_count);
                fail_count++;
            end
            else
            begin
                want = runs_due.pop_front();
                if (block_index !== want.blk)
                begin
                    $error("block_index: expected %0d, got %0d", want.blk, block_index);
                    fail_count++;
                end
                if (proc_number !== want.proc)
                begin
                    $error("proc_number: expected %0d, got %0d", want.proc, proc_number);
                    fail_count++;
                end
                if (element_count !== want.count)
                begin
                    $error("element_count: expected %0d, got %0d", want.count, element_count);
                    fail_count++;
                end
                if (last_run !== want.last)
                begin
                    $error("last_run: expected %0d, got %0d", want.last, last_run);
                    fail_count++;
                end
            end
        end

        // long hold-off on request, otherwise random stalls
        if (hold_request)
        begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 99) < 25)
        begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50)
                                                     : $urandom_range(0, 2);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    function automatic int pick_gap();
        int roll;

        if (quiet)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // mostly low levels, some mid, some above the saturation point
    function automatic logic [bepp_pkg::LEVEL_W-1:0] rand_level();
        int roll;

        roll = $urandom_range(0, 99);
        if (roll < 50)
            return bepp_pkg::LEVEL_W'($urandom_range(0, 4));
        if (roll < 85)
            return bepp_pkg::LEVEL_W'($urandom_range(0, bepp_pkg::MAX_LEVEL));
        return bepp_pkg::LEVEL_W'($urandom_range(bepp_pkg::MAX_LEVEL + 1, 15));
    endfunction

    // send one block request and predict on acceptance
    task automatic send_block(input logic [bepp_pkg::LEVEL_W-1:0] lx,
                              input logic [bepp_pkg::LEVEL_W-1:0] ly,
                              input logic [bepp_pkg::LEVEL_W-1:0] lz,
                              input logic is_last);
        int gap;

        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        ref_x      <= lx;
        ref_y      <= ly;
        ref_z      <= lz;
        last_block <= is_last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_partition(lx, ly, lz, is_last);
    endtask

    task automatic send_mesh(input int nblk);
        int i;

        for (i = 0; i < nblk; i++)
            send_block(rand_level(), rand_level(), rand_level(), i == nblk - 1);
    endtask

    // idle the sender, drain all runs, let the walk finish
    task automatic settle();
        in_valid <= 1'b0;
        while (runs_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // config write: setup then access, then read the register back
    task automatic write_cfg(input logic reg_idx, input logic [31:0] value);
        logic [31:0] want_rd;

        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == bepp_pkg::REG_NUM_PROCS)
        begin
            cfg_procs = value[5:0];
            want_rd   = {26'd0, value[5:0]};
        end
        else
        begin
            cfg_mask = value;
            want_rd  = value;
        end
        @(posedge clk);
        if (prdata !== want_rd)
        begin
            $error("prdata: expected %0h, got %0h", want_rd, prdata);
            fail_count++;
        end
        if (pready !== 1'b1)
        begin
            $error("pready: expected %0d, got %0d", 1'b1, pready);
            fail_count++;
        end
    endtask

    // single elements, saturated levels, largest blocks
    task automatic test_level_extremes();
        send_block(4'd0, 4'd0, 4'd0, 1'b1);
        send_block(4'd11, 4'd12, 4'd15, 1'b0);
        send_block(4'd15, 4'd15, 4'd15, 1'b1);
        send_block(4'd10, 4'd10, 4'd10, 1'b1);
    endtask

    // processor count out of range, ignored processors, idle processors
    task automatic test_proc_limits();
        settle();
        write_cfg(bepp_pkg::REG_NUM_PROCS, 32'd0);
        write_cfg(bepp_pkg::REG_IGNORE_MASK, 32'hFFFF_FFFF);
        send_block(4'd1, 4'd0, 4'd0, 1'b1);

        settle();
        write_cfg(bepp_pkg::REG_NUM_PROCS, 32'd63);
        write_cfg(bepp_pkg::REG_IGNORE_MASK, 32'hAAAA_AAAA);
        send_block(4'd2, 4'd1, 4'd1, 1'b0);
        send_block(4'd0, 4'd0, 4'd0, 1'b1);

        settle();
        write_cfg(bepp_pkg::REG_NUM_PROCS, 32'd33);
        write_cfg(bepp_pkg::REG_IGNORE_MASK, 32'h0000_0001);
        send_block(4'd5, 4'd0, 4'd0, 1'b0);
        send_block(4'd0, 4'd3, 4'd0, 1'b0);
        send_block(4'd0, 4'd0, 4'd4, 1'b1);
    endtask

    // more blocks than the store holds, last one dropped
    task automatic test_block_overflow();
        int i;

        settle();
        write_cfg(bepp_pkg::REG_NUM_PROCS, 32'd5);
        write_cfg(bepp_pkg::REG_IGNORE_MASK, 32'h0000_0014);
        for (i = 0; i <= bepp_pkg::MAX_BLOCKS; i++)
            send_block(bepp_pkg::LEVEL_W'(i % 4), bepp_pkg::LEVEL_W'(i % 3), 4'd0,
                       i == bepp_pkg::MAX_BLOCKS);
    endtask

    // receiver holds off while the sender keeps pushing the next mesh
    task automatic test_output_holdoff();
        settle();
        write_cfg(bepp_pkg::REG_NUM_PROCS, 32'd32);
        write_cfg(bepp_pkg::REG_IGNORE_MASK, 32'h0F0F_0000);
        quiet = 1'b1;
        hold_request = 1'b1;
        send_mesh(8);
        send_mesh(4);
        quiet = 1'b0;
    endtask

    // random meshes under random settings
    task automatic test_random_meshes();
        int sent;
        int nblk;
        int mesh_i;
        int roll;

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            settle();
            roll = $urandom_range(0, 99);
            if (roll < 15)
                write_cfg(bepp_pkg::REG_NUM_PROCS, 32'd0);
            else if (roll < 25)
                write_cfg(bepp_pkg::REG_NUM_PROCS, 32'd1);
            else if (roll < 40)
                write_cfg(bepp_pkg::REG_NUM_PROCS, 32'd32);
            else if (roll < 50)
                write_cfg(bepp_pkg::REG_NUM_PROCS, $urandom_range(33, 63));
            else
                write_cfg(bepp_pkg::REG_NUM_PROCS, $urandom_range(2, 31));
            roll = $urandom_range(0, 99);
            if (roll < 25)
                write_cfg(bepp_pkg::REG_IGNORE_MASK, 32'h0);
            else if (roll < 35)
                write_cfg(bepp_pkg::REG_IGNORE_MASK, 32'hFFFF_FFFF);
            else if (roll < 65)
                write_cfg(bepp_pkg::REG_IGNORE_MASK, $urandom & $urandom & $urandom);
            else
                write_cfg(bepp_pkg::REG_IGNORE_MASK, $urandom);

            for (mesh_i = 0; mesh_i < 6; mesh_i++)
            begin
                quiet = ($urandom_range(0, 4) == 0);
                roll = $urandom_range(0, 99);
                if (roll < 80)
                    nblk = $urandom_range(1, 8);
                else if (roll < 93)
                    nblk = $urandom_range(9, bepp_pkg::MAX_BLOCKS);
                else
                    nblk = $urandom_range(bepp_pkg::MAX_BLOCKS + 1, bepp_pkg::MAX_BLOCKS + 4);
                send_mesh(nblk);
                sent += nblk;
            end
        end
        quiet = 1'b0;
    endtask

    // sequence of tests
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_level_extremes();
        test_proc_limits();
        test_block_overflow();
        test_output_holdoff();
        test_random_meshes();

        settle();
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
